### sv/lzw_pkg.sv
// shared types and constants for the lz window stream decompressor
package lzw_pkg;

  localparam int unsigned HDR_LEN    = 16;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam logic [7:0]  MAGIC_Y    = 8'h59;
  localparam logic [7:0]  MAGIC_A    = 8'h61;
  localparam logic [7:0]  MAGIC_Z    = 8'h7A;
  localparam logic [7:0]  MAGIC_0    = 8'h30;
  localparam logic [7:0]  MAGIC_1    = 8'h31;
  localparam logic [3:0]  LEN_NIB_ADD = 4'h2;
  localparam logic [8:0]  LEN_EXT_ADD = 9'h012;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_MAGIC    = 3'd1,
    ST_BEFORE_START = 3'd2,
    ST_OVERRUN      = 3'd3,
    ST_PADDING      = 3'd4,
    ST_UNDERFILL    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_TOKEN,
    PH_REF1,
    PH_REF2
  } phase_t;

  typedef enum logic [1:0] {
    CMD_LIT,
    CMD_COPY,
    CMD_CLOSE
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_PUT,
    BK_CLOSE
  } back_state_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  lit;
    logic [11:0] dist_m1;
    logic [8:0]  len;
    status_t     status;
  } cmd_t;

endpackage

### sv/lzw_ram.sv
// generic single-port-write ram with registered read
module lzw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/lzw_fifo.sv
// short command queue between the parser and the copy engine
module lzw_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lzw_pkg::cmd_t push_cmd,
  input  logic          pop,
  output lzw_pkg::cmd_t pop_cmd,
  output logic          full,
  output logic          empty
);

  localparam int unsigned PW = $clog2(lzw_pkg::FIFO_DEPTH);

  lzw_pkg::cmd_t     slot_r [lzw_pkg::FIFO_DEPTH];
  logic [PW-1:0]     wptr_r, wptr_nxt;
  logic [PW-1:0]     rptr_r, rptr_nxt;
  logic [PW:0]       cnt_r, cnt_nxt;

  assign full    = (cnt_r == (PW+1)'(lzw_pkg::FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !full) begin
      wptr_nxt = wptr_r + 1'b1;
    end
    if (pop && !empty) begin
      rptr_nxt = rptr_r + 1'b1;
    end
    if ((push && !full) && !(pop && !empty)) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!(push && !full) && (pop && !empty)) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

endmodule

### sv/lzw_front.sv
// header and token parser that turns input bytes into copy commands
module lzw_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_byte,
  input  logic          in_eoi,
  output logic          push,
  output lzw_pkg::cmd_t push_cmd,
  input  logic          fifo_full
);

  logic [4:0]           hdr_pos_r, hdr_pos_nxt;
  logic [31:0]          size_r, size_nxt;
  logic [31:0]          bw_r, bw_nxt;
  logic [7:0]           flags_r, flags_nxt;
  logic [3:0]           idx_r, idx_nxt;
  lzw_pkg::phase_t      phase_r, phase_nxt;
  logic [15:0]          pend_r, pend_nxt;
  lzw_pkg::status_t     err_r, err_nxt;
  logic                 close_pend_r, close_pend_nxt;
  lzw_pkg::status_t     close_st_r, close_st_nxt;

  logic                 acc;
  logic                 do_copy;
  logic                 do_next_flag;
  logic [8:0]           copy_len;
  logic [12:0]          ref_dist;
  lzw_pkg::status_t     st;

  assign in_tready = !close_pend_r && !fifo_full;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    hdr_pos_nxt    = hdr_pos_r;
    size_nxt       = size_r;
    bw_nxt         = bw_r;
    flags_nxt      = flags_r;
    idx_nxt        = idx_r;
    phase_nxt      = phase_r;
    pend_nxt       = pend_r;
    err_nxt        = err_r;
    close_pend_nxt = close_pend_r;
    close_st_nxt   = close_st_r;
    push           = 1'b0;
    push_cmd       = '{kind: lzw_pkg::CMD_LIT, lit: in_byte, dist_m1: '0, len: 9'd1,
                       status: lzw_pkg::ST_OK};
    do_copy        = 1'b0;
    do_next_flag   = 1'b0;
    copy_len       = '0;
    ref_dist       = '0;
    st             = lzw_pkg::ST_OK;

    if (close_pend_r) begin
      if (!fifo_full) begin
        push           = 1'b1;
        push_cmd.kind  = lzw_pkg::CMD_CLOSE;
        push_cmd.status = close_st_r;
        close_pend_nxt = 1'b0;
      end
    end else if (acc) begin
      if (hdr_pos_r < 5'(lzw_pkg::HDR_LEN)) begin
        if ((hdr_pos_r == 5'd0 && in_byte != lzw_pkg::MAGIC_Y) ||
            (hdr_pos_r == 5'd1 && in_byte != lzw_pkg::MAGIC_A) ||
            (hdr_pos_r == 5'd2 && in_byte != lzw_pkg::MAGIC_Z) ||
            (hdr_pos_r == 5'd3 && in_byte != lzw_pkg::MAGIC_0 &&
             in_byte != lzw_pkg::MAGIC_1)) begin
          if (err_nxt == lzw_pkg::ST_OK) err_nxt = lzw_pkg::ST_BAD_MAGIC;
        end
        if (hdr_pos_r >= 5'd4 && hdr_pos_r <= 5'd7) begin
          size_nxt = {size_r[23:0], in_byte};
        end
        hdr_pos_nxt = hdr_pos_r + 5'd1;
      end else if (err_r == lzw_pkg::ST_BAD_MAGIC) begin
        // rest of the file is dropped
      end else if (size_r == '0) begin
        if (in_byte != 8'h00 && err_nxt == lzw_pkg::ST_OK) err_nxt = lzw_pkg::ST_PADDING;
      end else begin
        unique case (phase_r)
          lzw_pkg::PH_REF1: begin
            pend_nxt = pend_r | {8'h00, in_byte};
            if (pend_nxt[15:12] == 4'h0) begin
              phase_nxt = lzw_pkg::PH_REF2;
            end else begin
              phase_nxt = lzw_pkg::PH_TOKEN;
              do_copy   = 1'b1;
              copy_len  = {5'd0, pend_nxt[15:12]} + {5'd0, lzw_pkg::LEN_NIB_ADD};
            end
          end
          lzw_pkg::PH_REF2: begin
            phase_nxt = lzw_pkg::PH_TOKEN;
            do_copy   = 1'b1;
            copy_len  = {1'b0, in_byte} + lzw_pkg::LEN_EXT_ADD;
          end
          default: begin
            if (idx_r > 4'd7) begin
              flags_nxt = in_byte;
              idx_nxt   = 4'd7;
            end else if (flags_r[idx_r[2:0]]) begin
              push         = 1'b1;
              bw_nxt       = bw_r + 32'd1;
              size_nxt     = size_r - 32'd1;
              do_next_flag = 1'b1;
            end else begin
              pend_nxt  = {in_byte, 8'h00};
              phase_nxt = lzw_pkg::PH_REF1;
            end
          end
        endcase
        if (do_copy) begin
          ref_dist = {1'b0, pend_nxt[11:0]} + 13'd1;
          if ({19'd0, ref_dist} > bw_r && err_nxt == lzw_pkg::ST_OK) begin
            err_nxt = lzw_pkg::ST_BEFORE_START;
          end
          if ({23'd0, copy_len} > size_r) begin
            if (err_nxt == lzw_pkg::ST_OK) err_nxt = lzw_pkg::ST_OVERRUN;
            copy_len = size_r[8:0];
          end
          size_nxt         = size_r - {23'd0, copy_len};
          bw_nxt           = bw_r + {23'd0, copy_len};
          push             = 1'b1;
          push_cmd.kind    = lzw_pkg::CMD_COPY;
          push_cmd.dist_m1 = pend_nxt[11:0];
          push_cmd.len     = copy_len;
          do_next_flag     = 1'b1;
        end
        if (do_next_flag) begin
          idx_nxt = (idx_r == 4'd0 || idx_r > 4'd7) ? 4'd8 : idx_r - 4'd1;
        end
      end

      if (in_eoi) begin
        if (err_nxt != lzw_pkg::ST_OK) st = err_nxt;
        else if (hdr_pos_nxt < 5'(lzw_pkg::HDR_LEN)) st = lzw_pkg::ST_BAD_MAGIC;
        else if (size_nxt != '0) st = lzw_pkg::ST_UNDERFILL;
        else st = lzw_pkg::ST_OK;
        if (push) begin
          close_pend_nxt = 1'b1;
          close_st_nxt   = st;
        end else begin
          push            = 1'b1;
          push_cmd.kind   = lzw_pkg::CMD_CLOSE;
          push_cmd.status = st;
        end
        hdr_pos_nxt = '0;
        size_nxt    = '0;
        bw_nxt      = '0;
        flags_nxt   = '0;
        idx_nxt     = 4'd8;
        phase_nxt   = lzw_pkg::PH_TOKEN;
        pend_nxt    = '0;
        err_nxt     = lzw_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r    <= '0;
      size_r       <= '0;
      bw_r         <= '0;
      flags_r      <= '0;
      idx_r        <= 4'd8;
      phase_r      <= lzw_pkg::PH_TOKEN;
      pend_r       <= '0;
      err_r        <= lzw_pkg::ST_OK;
      close_pend_r <= 1'b0;
      close_st_r   <= lzw_pkg::ST_OK;
    end else begin
      hdr_pos_r    <= hdr_pos_nxt;
      size_r       <= size_nxt;
      bw_r         <= bw_nxt;
      flags_r      <= flags_nxt;
      idx_r        <= idx_nxt;
      phase_r      <= phase_nxt;
      pend_r       <= pend_nxt;
      err_r        <= err_nxt;
      close_pend_r <= close_pend_nxt;
      close_st_r   <= close_st_nxt;
    end
  end

endmodule

### sv/lzw_back.sv
// copy engine: history window, byte packing and output register
module lzw_back #(
  parameter int unsigned WINDOW_DEPTH = 4096,
  parameter int unsigned OUT_BYTES    = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fifo_empty,
  input  lzw_pkg::cmd_t pop_cmd,
  output logic          pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [63:0]   out_word,
  output logic [3:0]    out_count,
  output logic [2:0]    out_status,
  output logic          out_last
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned FW = $clog2(OUT_BYTES + 1);

  lzw_pkg::back_state_t state_r, state_nxt;
  logic [31:0]          bw_r, bw_nxt;
  logic [8:0]           len_r, len_nxt;
  logic [12:0]          dist_r, dist_nxt;
  logic [7:0]           lit_r, lit_nxt;
  logic                 is_lit_r, is_lit_nxt;
  logic                 zero_r, zero_nxt;
  lzw_pkg::status_t     cst_r, cst_nxt;
  logic [8*OUT_BYTES-1:0] acc_r, acc_nxt;
  logic [FW-1:0]        fill_r, fill_nxt;

  logic                 ov_r, ov_nxt;
  logic [63:0]          ow_r, ow_nxt;
  logic [3:0]           oc_r, oc_nxt;
  logic [2:0]           os_r, os_nxt;
  logic                 ol_r, ol_nxt;

  logic                 out_free;
  logic                 we, re;
  logic [AW-1:0]        raddr;
  logic [7:0]           rdata, pbyte;

  assign out_free   = !ov_r || out_tready;
  assign out_tvalid = ov_r;
  assign out_word   = ow_r;
  assign out_count  = oc_r;
  assign out_status = os_r;
  assign out_last   = ol_r;

  assign raddr = bw_r[AW-1:0] - AW'(dist_r);
  assign pbyte = is_lit_r ? lit_r : (zero_r ? 8'h00 : rdata);

  lzw_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_win (
    .clk   (clk),
    .we    (we),
    .waddr (bw_r[AW-1:0]),
    .wdata (pbyte),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    bw_nxt     = bw_r;
    len_nxt    = len_r;
    dist_nxt   = dist_r;
    lit_nxt    = lit_r;
    is_lit_nxt = is_lit_r;
    zero_nxt   = zero_r;
    cst_nxt    = cst_r;
    acc_nxt    = acc_r;
    fill_nxt   = fill_r;
    ov_nxt     = ov_r && !out_tready;
    ow_nxt     = ow_r;
    oc_nxt     = oc_r;
    os_nxt     = os_r;
    ol_nxt     = ol_r;
    pop        = 1'b0;
    we         = 1'b0;
    re         = 1'b0;

    unique case (state_r)
      lzw_pkg::BK_IDLE: begin
        if (!fifo_empty) begin
          pop      = 1'b1;
          lit_nxt  = pop_cmd.lit;
          len_nxt  = pop_cmd.len;
          dist_nxt = {1'b0, pop_cmd.dist_m1} + 13'd1;
          cst_nxt  = pop_cmd.status;
          unique case (pop_cmd.kind)
            lzw_pkg::CMD_LIT: begin
              is_lit_nxt = 1'b1;
              len_nxt    = 9'd1;
              state_nxt  = lzw_pkg::BK_PUT;
            end
            lzw_pkg::CMD_COPY: begin
              is_lit_nxt = 1'b0;
              state_nxt  = lzw_pkg::BK_READ;
            end
            default: state_nxt = lzw_pkg::BK_CLOSE;
          endcase
        end
      end
      lzw_pkg::BK_READ: begin
        re        = 1'b1;
        // positions before the first byte of the file read as zero
        zero_nxt  = ({19'd0, dist_r} > bw_r);
        state_nxt = lzw_pkg::BK_PUT;
      end
      lzw_pkg::BK_PUT: begin
        if (out_free) begin
          we       = 1'b1;
          bw_nxt   = bw_r + 32'd1;
          len_nxt  = len_r - 9'd1;
          acc_nxt[8*fill_r +: 8] = pbyte;
          fill_nxt = fill_r + 1'b1;
          if (fill_nxt == FW'(OUT_BYTES) || len_nxt == '0) begin
            ov_nxt   = 1'b1;
            ow_nxt   = 64'(acc_nxt);
            oc_nxt   = 4'(fill_nxt);
            os_nxt   = lzw_pkg::ST_OK;
            ol_nxt   = 1'b0;
            acc_nxt  = '0;
            fill_nxt = '0;
          end
          state_nxt = (len_nxt == '0) ? lzw_pkg::BK_IDLE : lzw_pkg::BK_READ;
        end
      end
      default: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ow_nxt    = '0;
          oc_nxt    = '0;
          os_nxt    = cst_r;
          ol_nxt    = 1'b1;
          bw_nxt    = '0;
          state_nxt = lzw_pkg::BK_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lzw_pkg::BK_IDLE;
      bw_r    <= '0;
      acc_r   <= '0;
      fill_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bw_r    <= bw_nxt;
      acc_r   <= acc_nxt;
      fill_r  <= fill_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r    <= len_nxt;
    dist_r   <= dist_nxt;
    lit_r    <= lit_nxt;
    is_lit_r <= is_lit_nxt;
    zero_r   <= zero_nxt;
    cst_r    <= cst_nxt;
    ow_r     <= ow_nxt;
    oc_r     <= oc_nxt;
    os_r     <= os_nxt;
    ol_r     <= ol_nxt;
  end

endmodule

### sv/lz_window_stream_decompressor.sv
// top level: parser, command queue and copy engine of the stream decompressor
// the parser takes one input byte per cycle while the command queue has room and no closing command is pending
// a literal is dequeued in the idle state and written to the output register from the put state once the output is free
// a back reference is copied byte by byte, with one window read then one write per byte
// a closing status transaction passes from the idle state through the close state into the output register
// rst_n is synchronous active low and clears all control state; the window is not cleared
module lz_window_stream_decompressor #(
  parameter int unsigned WINDOW_DEPTH = 4096,
  parameter int unsigned OUT_BYTES    = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // data_word[63:0], byte_count[67:64], status[70:68], pad
  output logic        out_tlast
);

  logic          push, pop, full, empty;
  lzw_pkg::cmd_t push_cmd, pop_cmd;
  logic [63:0]   word;
  logic [3:0]    count;
  logic [2:0]    status;

  lzw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_eoi    (in_tlast),
    .push      (push),
    .push_cmd  (push_cmd),
    .fifo_full (full)
  );

  lzw_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .full     (full),
    .empty    (empty)
  );

  lzw_back #(.WINDOW_DEPTH(WINDOW_DEPTH), .OUT_BYTES(OUT_BYTES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (empty),
    .pop_cmd    (pop_cmd),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_word   (word),
    .out_count  (count),
    .out_status (status),
    .out_last   (out_tlast)
  );

  assign out_tdata = {1'b0, status, count, word};

endmodule

### sv/lzw_chk.sv
// port-level checker for the stream decompressor, bound to the top level
module lzw_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output transaction dropped while stalled");

  a_close_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[67:64] == 4'd0 && out_tdata[63:0] == 64'd0)
    else $error("closing transaction carries data");

  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[70:68] == 3'd0 && out_tdata[67:64] != 4'd0)
    else $error("data transaction with status or no bytes");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[67:64] <= 4'd8 && out_tdata[71] == 1'b0)
    else $error("byte count out of range");

endmodule

bind lz_window_stream_decompressor lzw_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

### bench/tb_lz_window_stream_decompressor.sv
// self-checking testbench for the streaming lz window decompressor
`timescale 1ns / 100ps

typedef struct {
  bit [63:0]        word;
  bit [3:0]         count;
  bit               last;
  lzw_pkg::status_t status;
} decoded_word_t;

class decomp_scoreboard;
  bit [7:0]         window [4096];
  int unsigned      hdr_pos;
  bit [31:0]        size_left;
  bit [31:0]        written;
  bit [7:0]         flags;
  int               flag_idx;
  lzw_pkg::phase_t  phase;
  bit [15:0]        pend_ref;
  lzw_pkg::status_t first_err;
  bit [63:0]        acc;
  int unsigned      fill;
  decoded_word_t    pending_words[$];
  int unsigned      mismatches;
  int unsigned      words_seen;
  int unsigned      files_closed;
  int unsigned      status_seen[8];

  function void restart();
    hdr_pos   = 0;
    size_left = 0;
    written   = 0;
    flags     = 0;
    flag_idx  = 8;
    phase     = lzw_pkg::PH_TOKEN;
    pend_ref  = 0;
    first_err = lzw_pkg::ST_OK;
  endfunction

  function void note_err(lzw_pkg::status_t code);
    if (first_err == lzw_pkg::ST_OK) first_err = code;
  endfunction

  function void queue_word(bit [63:0] w, bit [3:0] c, bit l, lzw_pkg::status_t s);
    decoded_word_t r;
    r.word   = w;
    r.count  = c;
    r.last   = l;
    r.status = s;
    pending_words = {pending_words, r};
  endfunction

  function void flush();
    if (fill != 0) begin
      queue_word(acc, fill[3:0], 1'b0, lzw_pkg::ST_OK);
      acc  = 0;
      fill = 0;
    end
  endfunction

  function void emit(bit [7:0] b);
    window[written % 4096] = b;
    written++;
    size_left--;
    acc |= 64'(b) << (8 * fill);
    fill++;
    if (fill >= 8) flush();
  endfunction

  function void advance_flag();
    if (flag_idx == 0 || flag_idx > 7) flag_idx = 8;
    else flag_idx--;
  endfunction

  function void copy_back(int unsigned len);
    bit [31:0] ref_dist;
    bit [7:0]  b;
    ref_dist = 32'(pend_ref[11:0]) + 1;
    if (ref_dist > written) note_err(lzw_pkg::ST_BEFORE_START);
    if (len > size_left) begin
      note_err(lzw_pkg::ST_OVERRUN);
      len = size_left;
    end
    for (int unsigned i = 0; i < len; i++) begin
      b = 0;
      if (ref_dist <= written) b = window[(written - ref_dist) % 4096];
      emit(b);
    end
  endfunction

  function void take_token(bit [7:0] b);
    if (phase == lzw_pkg::PH_REF1) begin
      pend_ref = pend_ref | 16'(b);
      if (pend_ref[15:12] == 0) begin
        phase = lzw_pkg::PH_REF2;
      end else begin
        phase = lzw_pkg::PH_TOKEN;
        copy_back(pend_ref[15:12] + 2);
        advance_flag();
      end
    end else if (phase == lzw_pkg::PH_REF2) begin
      phase = lzw_pkg::PH_TOKEN;
      copy_back(int'(b) + 18);
      advance_flag();
    end else if (flag_idx > 7) begin
      flags    = b;
      flag_idx = 7;
    end else if (flags[flag_idx]) begin
      emit(b);
      advance_flag();
    end else begin
      pend_ref = {b, 8'h00};
      phase    = lzw_pkg::PH_REF1;
    end
  endfunction

  function void note_input(bit [7:0] b, bit eoi);
    lzw_pkg::status_t s;
    acc  = 0;
    fill = 0;
    if (hdr_pos < lzw_pkg::HDR_LEN) begin
      if ((hdr_pos == 0 && b != lzw_pkg::MAGIC_Y) || (hdr_pos == 1 && b != lzw_pkg::MAGIC_A) ||
          (hdr_pos == 2 && b != lzw_pkg::MAGIC_Z) ||
          (hdr_pos == 3 && b != lzw_pkg::MAGIC_0 && b != lzw_pkg::MAGIC_1))
        note_err(lzw_pkg::ST_BAD_MAGIC);
      if (hdr_pos >= 4 && hdr_pos <= 7) size_left = {size_left[23:0], b};
      hdr_pos++;
    end else if (first_err == lzw_pkg::ST_BAD_MAGIC) begin
      // rest of a bad file is dropped
    end else if (size_left == 0) begin
      if (b != 0) note_err(lzw_pkg::ST_PADDING);
    end else begin
      take_token(b);
    end
    flush();
    if (eoi) begin
      if (first_err != lzw_pkg::ST_OK) s = first_err;
      else if (hdr_pos < lzw_pkg::HDR_LEN) s = lzw_pkg::ST_BAD_MAGIC;
      else if (size_left != 0) s = lzw_pkg::ST_UNDERFILL;
      else s = lzw_pkg::ST_OK;
      queue_word(0, 0, 1'b1, s);
      restart();
    end
  endfunction

  function void check(bit [71:0] tdata, bit tlast);
    decoded_word_t e;
    words_seen++;
    if (pending_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected transaction: data %h last %0d", tdata, tlast);
      return;
    end
    e = pending_words.pop_front();
    if (e.last) begin
      files_closed++;
      status_seen[e.status]++;
    end
    if (tdata[63:0] != e.word || tdata[67:64] != e.count || tdata[70:68] != e.status ||
        tlast != e.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected word %h count %0d status %0d last %0d, got %h %0d %0d %0d",
                 e.word, e.count, e.status, e.last, tdata[63:0], tdata[67:64],
                 tdata[70:68], tlast);
    end
  endfunction
endclass

module tb_lz_window_stream_decompressor;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 400;

  localparam int M_CLEAN = 0;
  localparam int M_EARLY = 1;
  localparam int M_OVER  = 2;
  localparam int M_PAD   = 3;
  localparam int M_UNDER = 4;

  localparam int MAG_YAZ0 = 0;
  localparam int MAG_YAZ1 = 1;
  localparam int MAG_BAD  = 2;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic        out_tlast;

  decomp_scoreboard sb;
  bit [7:0]    stream[$];
  bit          stream_end[$];
  int unsigned send_idle;
  int unsigned recv_idle;
  bit          hold_req;
  int unsigned quiet_cycles;

  lz_window_stream_decompressor i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void add_byte(bit [7:0] b);
    stream     = {stream, b};
    stream_end = {stream_end, 1'b0};
  endfunction

  function automatic void add_header(int magic, bit [31:0] size, int unsigned len);
    bit [7:0] hdr[16];
    hdr[0] = lzw_pkg::MAGIC_Y;
    hdr[1] = (magic == MAG_BAD) ? 8'h41 : lzw_pkg::MAGIC_A;
    hdr[2] = lzw_pkg::MAGIC_Z;
    hdr[3] = (magic == MAG_YAZ1) ? lzw_pkg::MAGIC_1 : lzw_pkg::MAGIC_0;
    for (int k = 0; k < 4; k++) hdr[4 + k] = size[8 * (3 - k) +: 8];
    for (int k = 8; k < 16; k++) hdr[k] = 8'($urandom);
    for (int k = 0; k < len; k++) add_byte(hdr[k]);
  endfunction

  // one compressed file: header, groups with literals and references, optional padding or a cut tail
  function automatic void gen_file(int unsigned size, int magic, int mode, bit go_long);
    bit [7:0]    toks[$];
    bit [7:0]    grp;
    int unsigned made;
    int unsigned room;
    int unsigned len;
    bit [11:0]   dist_m1;
    bit          first_ref;
    bit          take_ref;
    add_header(magic, size, 16);
    made      = 0;
    first_ref = 1'b1;
    while (made < size) begin
      grp = 8'($urandom);
      toks.delete();
      for (int k = 7; k >= 0; k--) begin
        room = size - made;
        if (room == 0) break;
        take_ref = 1'b0;
        if (mode == M_EARLY && first_ref && room >= 3) take_ref = 1'b1;
        else if (mode == M_OVER && room <= 15 && made > 0) take_ref = 1'b1;
        else if (room >= 3 && made > 0 && $urandom_range(0, 2) == 0) take_ref = 1'b1;
        if (take_ref) begin
          grp[k] = 1'b0;
          if (mode == M_EARLY && first_ref) dist_m1 = 12'(made + $urandom_range(0, 20));
          else dist_m1 = 12'($urandom_range(0, made - 1));
          if (go_long && room >= 273) len = 273;
          else if (mode == M_OVER && room <= 15) len = room + 2;
          else if (room >= 18 && $urandom_range(0, 3) == 0)
            len = 18 + $urandom_range(0, (room - 18 > 255) ? 255 : room - 18);
          else len = $urandom_range(3, (room > 17) ? 17 : room);
          if (len >= 18) begin
            toks = {toks, {4'h0, dist_m1[11:8]}};
            toks = {toks, dist_m1[7:0]};
            toks = {toks, 8'(len - 18)};
          end else begin
            toks = {toks, {4'(len - 2), dist_m1[11:8]}};
            toks = {toks, dist_m1[7:0]};
          end
          made += (len > room) ? room : len;
          first_ref = 1'b0;
        end else begin
          grp[k] = 1'b1;
          toks = {toks, 8'($urandom)};
          made++;
        end
      end
      add_byte(grp);
      foreach (toks[i]) add_byte(toks[i]);
    end
    if (mode == M_PAD) add_byte(8'($urandom_range(1, 255)));
    else if (mode != M_UNDER && $urandom_range(0, 1) == 1) add_byte(8'h00);
    if (mode == M_UNDER) begin
      // cut the tail, possibly inside a token
      len = $urandom_range(1, 3);
      for (int k = 0; k < len && stream.size() > 17; k++) begin
        void'(stream.pop_back());
        void'(stream_end.pop_back());
      end
    end
    stream_end[stream_end.size() - 1] = 1'b1;
  endfunction

  task automatic send_stream();
    int unsigned n;
    n = stream.size();
    for (int unsigned i = 0; i < n; i++) begin
      if (i < n / 3) begin
        send_idle = 38;
        recv_idle = 60;
      end else if (i < 2 * n / 3) begin
        send_idle = 60;
        recv_idle = 38;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (i == 5 * n / 6) hold_req = 1'b1;
      while ($urandom_range(0, 99) < send_idle) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= stream[i];
      in_tlast  <= stream_end[i];
      do @(posedge clk); while (!in_tready);
      sb.note_input(stream[i], stream_end[i]);
      @(negedge clk);
    end
    in_tvalid <= 1'b0;
  endtask

  // result side: random back-pressure plus one long hold-off
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_tready <= 1'b0;
        end
      end
      @(negedge clk);
      out_tready <= ($urandom_range(0, 99) >= recv_idle);
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check(out_tdata, out_tlast);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    sb.restart();
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = 8'h00;
    in_tlast     = 1'b0;
    hold_req     = 1'b0;
    send_idle    = 0;
    recv_idle    = 0;
    quiet_cycles = 0;

    // directed files
    gen_file(20, MAG_YAZ0, M_CLEAN, 1'b0);
    gen_file(280, MAG_YAZ1, M_CLEAN, 1'b1);
    gen_file(0, MAG_YAZ0, M_CLEAN, 1'b0);
    gen_file(10, MAG_BAD, M_CLEAN, 1'b0);
    add_header(MAG_YAZ0, 8, 6);
    stream_end[stream_end.size() - 1] = 1'b1;
    gen_file(12, MAG_YAZ0, M_EARLY, 1'b0);
    gen_file(14, MAG_YAZ0, M_OVER, 1'b0);
    gen_file(9, MAG_YAZ0, M_PAD, 1'b0);
    gen_file(16, MAG_YAZ1, M_UNDER, 1'b0);
    gen_file(10, MAG_YAZ0, M_PAD, 1'b0);
    stream[stream.size() - 2] = 8'hFF;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_stream();
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("sent %0d compressed bytes in %0d files, checked %0d output transactions",
             stream.size(), sb.files_closed, sb.words_seen);
    $display("closing status counts ok/magic/early/overrun/pad/under: %0d %0d %0d %0d %0d %0d",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
             sb.status_seen[4], sb.status_seen[5]);
    if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending_words.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
